FILE: hw/rtl/rrre_pkg.sv
package rrre_pkg;

	// Largest image the counters are sized for.
	localparam int MAX_WIDTH  = 4096;
	localparam int MAX_HEIGHT = 4096;

	localparam int COL_W   = $clog2(MAX_WIDTH);
	localparam int ROW_W   = $clog2(MAX_HEIGHT);
	localparam int DIM_W   = 13;
	localparam int ORG_W   = 15;
	localparam int COORD_W = 16;

	localparam logic [DIM_W-1:0] WIDTH_MAX  = DIM_W'(MAX_WIDTH);
	localparam logic [DIM_W-1:0] HEIGHT_MAX = DIM_W'(MAX_HEIGHT);

	// Configuration register indexes.
	localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd0;
	localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd1;
	localparam logic [1:0] REG_ORIGIN_X     = 2'd2;
	localparam logic [1:0] REG_ORIGIN_Y     = 2'd3;

	localparam int PIXEL_BITS = 32;
	localparam int RUN_BITS   = 80;

	typedef struct packed {
		logic                last;
		logic [7:0]          alpha;
		logic [7:0]          blue;
		logic [7:0]          green;
		logic [7:0]          red;
		logic [DIM_W-1:0]    width;
		logic [COORD_W-1:0]  y;
		logic [COORD_W-1:0]  x;
	} run_t;

endpackage

FILE: hw/rtl/rgba_row_run_encoder.sv
// Channel   | Direction | Word
// ----------+-----------+--------------------------------------------------
// s_axis    | in        | one RGBA pixel, raster order
// m_axis    | out       | one run rectangle; tlast marks the pixel's last run
// cfg       | in        | register index and write data
//
// Pixels are taken one per clock while s_axis_tready is high. A pixel is
// registered, then compared with the open run and its runs are written
// into a four-word result queue; results leave one per clock while
// m_axis_tready is high, and the queue absorbs a pixel that closes two runs.
// The pixel register advances only while the queue has room for two words,
// so the queue never overflows and m_axis stalls never reach s_axis
// combinationally. arst_n clears the counters, run state and queue at once.
module rgba_row_run_encoder (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	// pixel_red, pixel_green, pixel_blue, pixel_alpha from the lowest bit up
	input  logic [rrre_pkg::PIXEL_BITS-1:0] s_axis_tdata,
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	// run_x, run_y, run_width, run_red, run_green, run_blue, run_alpha,
	// then three zero bits, from the lowest bit up
	output logic [rrre_pkg::RUN_BITS-1:0]  m_axis_tdata,
	// final_of_pixel
	output logic                           m_axis_tlast,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [1:0]                     cfg_index,
	input  logic [rrre_pkg::ORG_W-1:0]     cfg_data
);
	import rrre_pkg::*;

	// Configuration registers.
	logic [DIM_W-1:0] width_q;
	logic [DIM_W-1:0] height_q;
	logic [ORG_W-1:0] origin_x_q;
	logic [ORG_W-1:0] origin_y_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q    <= WIDTH_MAX;
			height_q   <= HEIGHT_MAX;
			origin_x_q <= '0;
			origin_y_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_IMAGE_WIDTH:  width_q    <= cfg_data[DIM_W-1:0];
				REG_IMAGE_HEIGHT: height_q   <= cfg_data[DIM_W-1:0];
				REG_ORIGIN_X:     origin_x_q <= cfg_data;
				REG_ORIGIN_Y:     origin_y_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Pixel register stage.
	logic                  valid_s1;
	logic [PIXEL_BITS-1:0] pixel_s1;
	logic                  advance;

	logic [2:0] count_q;
	assign advance       = valid_s1 && (count_q <= 3'd2);
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			pixel_s1 <= s_axis_tdata;
		end
	end

	// Run state.
	logic [COL_W-1:0] column_q;
	logic [ROW_W-1:0] row_q;
	logic [COL_W-1:0] run_start_q;
	logic [31:0]      run_colour_q;
	logic             seen_opaque_q;

	// Effective image size, saturated to 1..MAX.
	logic [DIM_W-1:0] width_eff;
	logic [DIM_W-1:0] height_eff;

	always_comb begin
		if (width_q == '0) begin
			width_eff = DIM_W'(1);
		end else if (width_q > WIDTH_MAX) begin
			width_eff = WIDTH_MAX;
		end else begin
			width_eff = width_q;
		end
		if (height_q == '0) begin
			height_eff = DIM_W'(1);
		end else if (height_q > HEIGHT_MAX) begin
			height_eff = HEIGHT_MAX;
		end else begin
			height_eff = height_q;
		end
	end

	logic [31:0]      key;
	logic             first_col;
	logic             changed;
	logic             old_opaque;
	logic             emit_closed;
	logic             row_end;
	logic             image_end;
	logic             emit_tail;
	logic [COL_W-1:0] start_n;
	logic [31:0]      colour_n;
	logic             seen_n;
	logic [COORD_W-1:0] row_y;
	run_t             closed_run;
	run_t             tail_run;
	run_t             word0;
	run_t             word1;
	logic [1:0]       push_n;

	always_comb begin
		// A transparent pixel keys as all zero, whatever its colour bytes.
		key        = (pixel_s1[31:24] != 8'd0)
			? {pixel_s1[7:0], pixel_s1[15:8], pixel_s1[23:16], pixel_s1[31:24]}
			: 32'd0;
		first_col  = (column_q == '0);
		changed    = (key != run_colour_q);
		old_opaque = (run_colour_q[7:0] != 8'd0);

		// An interior transparent run goes out only once the row has had an
		// opaque run, i.e. when an opaque pixel closes it.
		emit_closed = !first_col && changed && (old_opaque || seen_opaque_q);

		if (first_col) begin
			start_n  = '0;
			colour_n = key;
			seen_n   = 1'b0;
		end else if (changed) begin
			start_n  = column_q;
			colour_n = key;
			seen_n   = seen_opaque_q || old_opaque;
		end else begin
			start_n  = run_start_q;
			colour_n = run_colour_q;
			seen_n   = seen_opaque_q;
		end

		row_end   = ({1'b0, column_q} >= (width_eff - DIM_W'(1)));
		image_end = ({1'b0, row_q} >= (height_eff - DIM_W'(1)));
		emit_tail = row_end && (colour_n[7:0] != 8'd0);

		row_y = {origin_y_q[ORG_W-1], origin_y_q}
			+ COORD_W'(row_q);

		closed_run.x     = {origin_x_q[ORG_W-1], origin_x_q} + COORD_W'(run_start_q);
		closed_run.y     = row_y;
		closed_run.width = {1'b0, column_q} - {1'b0, run_start_q};
		closed_run.red   = run_colour_q[31:24];
		closed_run.green = run_colour_q[23:16];
		closed_run.blue  = run_colour_q[15:8];
		closed_run.alpha = run_colour_q[7:0];
		closed_run.last  = !emit_tail;

		tail_run.x     = {origin_x_q[ORG_W-1], origin_x_q} + COORD_W'(start_n);
		tail_run.y     = row_y;
		tail_run.width = {1'b0, column_q} + DIM_W'(1) - {1'b0, start_n};
		tail_run.red   = colour_n[31:24];
		tail_run.green = colour_n[23:16];
		tail_run.blue  = colour_n[15:8];
		tail_run.alpha = colour_n[7:0];
		tail_run.last  = 1'b1;

		// The closed run comes before the run that ends at the row's end.
		word0  = emit_closed ? closed_run : tail_run;
		word1  = tail_run;
		push_n = {1'b0, emit_closed} + {1'b0, emit_tail};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_q      <= '0;
			row_q         <= '0;
			run_start_q   <= '0;
			run_colour_q  <= '0;
			seen_opaque_q <= 1'b0;
		end else if (advance) begin
			run_start_q   <= start_n;
			run_colour_q  <= colour_n;
			seen_opaque_q <= seen_n;
			if (row_end) begin
				column_q <= '0;
				row_q    <= image_end ? '0 : row_q + ROW_W'(1);
			end else begin
				column_q <= column_q + COL_W'(1);
			end
		end
	end

	// Result queue, four words deep.
	run_t       queue_q [4];
	logic [1:0] wr_ptr_q;
	logic [1:0] rd_ptr_q;
	logic [1:0] push;
	logic       pop;

	assign push = advance ? push_n : 2'd0;
	assign pop  = m_axis_tvalid && m_axis_tready;

	always_ff @(posedge clk) begin
		if (push != 2'd0) begin
			queue_q[wr_ptr_q] <= word0;
		end
		if (push == 2'd2) begin
			queue_q[wr_ptr_q + 2'd1] <= word1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + push;
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 2'd1;
			end
			count_q <= count_q + {1'b0, push} - {2'b0, pop};
		end
	end

	run_t head;
	assign head          = queue_q[rd_ptr_q];
	assign m_axis_tvalid = (count_q != '0);
	assign m_axis_tlast  = head.last;
	assign m_axis_tdata  = {3'b000, head.alpha, head.blue, head.green, head.red,
		head.width, head.y, head.x};

endmodule

FILE: hw/rtl/rrre_checker.sv
module rrre_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	input  logic [rrre_pkg::RUN_BITS-1:0]  m_axis_tdata,
	input  logic                           m_axis_tlast
);
	import rrre_pkg::*;

	// A stalled run word holds.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
			&& $stable(m_axis_tlast))
		else $error("stalled run word changed");

	// Every run covers at least one pixel and no more than a row.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[44:32] != 13'd0
			&& m_axis_tdata[44:32] <= WIDTH_MAX)
		else $error("run width out of range");

	// A transparent run carries zero colour bytes.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[76:69] == 8'd0 |-> m_axis_tdata[68:45] == 24'd0)
		else $error("transparent run with colour");

	// Padding bits stay zero.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[79:77] == 3'd0)
		else $error("padding bits set");

endmodule

bind rgba_row_run_encoder rrre_checker u_rrre_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tlast  (m_axis_tlast)
);
